/* sv/wsenc_pkg.sv */
// shared types, constants and the bit expansion function of the ws2812 spi encoder
`default_nettype none

package wsenc_pkg;

  localparam int MaxLeds     = 64;
  localparam int ResetBytes  = 240;
  localparam int MaxGapItems = 20;

  localparam int GapItemsRaw = (ResetBytes + 11) / 12;
  localparam int GapItems    = (GapItemsRaw > MaxGapItems) ? MaxGapItems : GapItemsRaw;
  localparam int GapCntW     = $clog2(GapItems + 1);

  localparam int LedCountW   = 7;
  localparam int PosW        = $clog2(MaxLeds);
  localparam int GuardW      = 4;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 7;

  localparam int FifoDepth   = 2;
  localparam int FifoPtrW    = $clog2(FifoDepth);
  localparam int FifoCntW    = $clog2(FifoDepth + 1);

  localparam logic [3:0]  NibOne    = 4'hE;
  localparam logic [3:0]  NibZero   = 4'h8;
  localparam logic [31:0] GuardCode = 32'h8888_8888;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLOR_ORDER = 2'd0,
    CFG_LED_COUNT   = 2'd1,
    CFG_TAIL_GUARD  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_GUARD = 2'd1,
    KIND_GAP   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_PIXEL,
    PH_GUARD,
    PH_GAP
  } phase_e;

  // one classified pixel waiting for the back end
  typedef struct packed {
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    logic [7:0]        third_byte;
    logic              frame_last;
    logic [GuardW-1:0] guard_count;
  } entry_t;

  // each data bit becomes four spi bits, msb first
  function automatic logic [31:0] expand_byte(input logic [7:0] data);
    logic [31:0] code;
    code = '0;
    for (int b = 0; b < 8; b++) begin
      code[b*4 +: 4] = data[b] ? NibOne : NibZero;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* sv/wsenc_front.sv */
// front end: configuration registers, channel reordering and frame position tracking
`default_nettype none

module wsenc_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [wsenc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wsenc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [23:0]                  s_axis_tdata,
  input  wire logic                         full_i,
  output logic                              push_o,
  output wsenc_pkg::entry_t                 entry_o
);
  import wsenc_pkg::*;

  logic                 color_order_q;
  logic [LedCountW-1:0] led_count_q;
  logic [GuardW-1:0]    tail_guard_q;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [LedCountW-1:0] count_eff;
  logic [LedCountW-1:0] pos_next;
  logic                 frame_last;
  logic [7:0]           red, green, blue;

  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_order_q <= 1'b0;
      led_count_q   <= LedCountW'(1);
      tail_guard_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOR_ORDER: color_order_q <= cfg_wdata_i[0];
        CFG_LED_COUNT:   led_count_q   <= cfg_wdata_i[LedCountW-1:0];
        CFG_TAIL_GUARD:  tail_guard_q  <= cfg_wdata_i[GuardW-1:0];
        default: ;
      endcase
    end
  end

  // zero count acts as one, large counts saturate
  always_comb begin
    if (led_count_q == '0) begin
      count_eff = LedCountW'(1);
    end else if (led_count_q > LedCountW'(MaxLeds)) begin
      count_eff = LedCountW'(MaxLeds);
    end else begin
      count_eff = led_count_q;
    end
  end

  assign pos_next   = LedCountW'(pos_q) + LedCountW'(1);
  assign frame_last = !(pos_next < count_eff);

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = frame_last ? '0 : pos_next[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_comb begin
    entry_o.first_byte  = color_order_q ? red : green;
    entry_o.second_byte = color_order_q ? green : red;
    entry_o.third_byte  = blue;
    entry_o.frame_last  = frame_last;
    entry_o.guard_count = tail_guard_q;
  end

endmodule

`default_nettype wire

/* sv/wsenc_fifo.sv */
// short queue that decouples the front end from the emitting back end
`default_nettype none

module wsenc_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wsenc_pkg::entry_t      entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output wsenc_pkg::entry_t      entry_o
);
  import wsenc_pkg::*;

  entry_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

/* sv/wsenc_back.sv */
// back end: spi code expansion, guard and reset gap burst, output register
`default_nettype none

module wsenc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fifo_valid_i,
  input  wsenc_pkg::entry_t  fifo_entry_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [95:0]        m_axis_tdata,
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast
);
  import wsenc_pkg::*;

  phase_e             phase_q, phase_d;
  logic [GuardW-1:0]  guard_left_q, guard_left_d;
  logic [GapCntW-1:0] gap_cnt_q, gap_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [95:0]        out_data_q, out_data_d;
  kind_e              out_kind_q, out_kind_d;
  logic               out_last_q, out_last_d;
  logic               load;

  assign load = !out_valid_q || m_axis_tready;

  always_comb begin
    phase_d      = phase_q;
    guard_left_d = guard_left_q;
    gap_cnt_d    = gap_cnt_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_kind_d   = out_kind_q;
    out_last_d   = out_last_q;
    pop_o        = 1'b0;
    if (load) begin
      unique case (phase_q)
        PH_GUARD: begin
          out_valid_d  = 1'b1;
          out_data_d   = {GuardCode, GuardCode, GuardCode};
          out_kind_d   = KIND_GUARD;
          out_last_d   = 1'b0;
          guard_left_d = guard_left_q - GuardW'(1);
          if (guard_left_q == GuardW'(1)) begin
            phase_d   = PH_GAP;
            gap_cnt_d = '0;
          end
        end
        PH_GAP: begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_kind_d  = KIND_GAP;
          out_last_d  = (gap_cnt_q == GapCntW'(GapItems - 1));
          if (gap_cnt_q == GapCntW'(GapItems - 1)) begin
            phase_d = PH_PIXEL;
          end else begin
            gap_cnt_d = gap_cnt_q + GapCntW'(1);
          end
        end
        default: begin
          out_valid_d = fifo_valid_i;
          if (fifo_valid_i) begin
            pop_o      = 1'b1;
            out_data_d = {expand_byte(fifo_entry_i.third_byte),
                          expand_byte(fifo_entry_i.second_byte),
                          expand_byte(fifo_entry_i.first_byte)};
            out_kind_d = KIND_PIXEL;
            out_last_d = 1'b0;
            if (fifo_entry_i.frame_last) begin
              if (fifo_entry_i.guard_count != '0) begin
                phase_d      = PH_GUARD;
                guard_left_d = fifo_entry_i.guard_count;
              end else begin
                phase_d   = PH_GAP;
                gap_cnt_d = '0;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PIXEL;
      guard_left_q <= '0;
      gap_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      guard_left_q <= guard_left_d;
      gap_cnt_q    <= gap_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  a_last_is_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_kind_q == KIND_GAP))
    else $error("frame end on a non-gap item");

  a_guard_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GUARD) |-> (guard_left_q != '0))
    else $error("guard phase with no guard items left");

  a_gap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_cnt_q < GapCntW'(GapItems))
    else $error("gap counter out of range");

  a_no_pop_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (phase_q == PH_PIXEL && fifo_valid_i))
    else $error("pixel taken during padding burst");

endmodule

`default_nettype wire

/* sv/ws2812_spi_frame_encoder_unit.sv */
// top level of the ws2812 spi frame encoder
// Takes one rgb pixel per item and returns one 96-bit item of three 32-bit spi codes
// (four spi bits per data bit, 1 -> 1110, 0 -> 1000). Each pixel's output item passes
// through the queue register, then the output register, and pixels stream at one item
// per clock while the receiver is ready and no guard or gap burst runs. After the last
// pixel of a frame the back end emits the programmed number of black guard items and then
// 20 all-zero reset gap items, the last with tlast high, one per clock from its emit
// counter while the receiver is ready; the input keeps accepting into the two-entry queue
// and stalls once it is full, so a frame of n pixels and g guard items has n + g + 20 items.
`default_nettype none

module ws2812_spi_frame_encoder_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wsenc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wsenc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [23:0]                    s_axis_tdata,  // red, green, blue
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [95:0]                         m_axis_tdata,  // first_code, second_code, third_code
  output logic [1:0]                          m_axis_tuser,  // item_kind
  output logic                                m_axis_tlast   // frame_end
);
  import wsenc_pkg::*;

  entry_t push_entry, pop_entry;
  logic   push, pop, full, fifo_valid;

  wsenc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  wsenc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .entry_o (pop_entry)
  );

  wsenc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_valid_i  (fifo_valid),
    .fifo_entry_i  (pop_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* dv/ws2812_spi_frame_encoder_unit_checker.sv */
// scoreboard for the ws2812 spi frame encoder: tracks config, predicts spi items and compares
`timescale 1ns / 100ps

module ws2812_spi_frame_encoder_unit_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wsenc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wsenc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  input  wire logic                           s_axis_tready,
  input  wire logic [23:0]                    s_axis_tdata,  // red, green, blue
  input  wire logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic [95:0]                    m_axis_tdata,  // first_code, second_code, third_code
  input  wire logic [1:0]                     m_axis_tuser,  // item_kind
  input  wire logic                           m_axis_tlast,  // frame_end
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import wsenc_pkg::*;

  localparam int GapRaw = (ResetBytes + 11) / 12;
  localparam int GapLen = (GapRaw > 20) ? 20 : GapRaw;
  localparam logic [31:0] BlackCode = 32'h8888_8888;

  typedef struct packed {
    logic [31:0] first_code;
    logic [31:0] second_code;
    logic [31:0] third_code;
    kind_e       kind;
    logic        frame_end;
  } spi_item_t;

  spi_item_t   spi_q[$];
  logic        rgb_order;
  logic [6:0]  leds_per_frame;
  logic [3:0]  guard_len;
  int          pixel_pos;
  int          fails;

  // msb first, 1 -> 1110, 0 -> 1000
  function automatic logic [31:0] spi_code(input logic [7:0] value);
    logic [31:0] code;
    code = '0;
    for (int i = 7; i >= 0; i--) begin
      code = {code[27:0], (value[i] ? 4'hE : 4'h8)};
    end
    return code;
  endfunction

  function automatic spi_item_t make_item(input logic [31:0] c0, input logic [31:0] c1,
                                          input logic [31:0] c2, input kind_e kind,
                                          input logic frame_end);
    spi_item_t it;
    it.first_code  = c0;
    it.second_code = c1;
    it.third_code  = c2;
    it.kind        = kind;
    it.frame_end   = frame_end;
    return it;
  endfunction

  task automatic predict_pixel(input logic [23:0] rgb);
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    int         count;
    red   = rgb[7:0];
    green = rgb[15:8];
    blue  = rgb[23:16];
    count = int'(leds_per_frame);
    if (count == 0) count = 1;
    if (count > MaxLeds) count = MaxLeds;
    if (rgb_order) begin
      spi_q.push_back(make_item(spi_code(red), spi_code(green), spi_code(blue), KIND_PIXEL, 1'b0));
    end else begin
      spi_q.push_back(make_item(spi_code(green), spi_code(red), spi_code(blue), KIND_PIXEL, 1'b0));
    end
    if (pixel_pos + 1 < count) begin
      pixel_pos++;
    end else begin
      // frame done: black guard pixels, then the zero reset gap
      pixel_pos = 0;
      for (int i = 0; i < int'(guard_len); i++) begin
        spi_q.push_back(make_item(BlackCode, BlackCode, BlackCode, KIND_GUARD, 1'b0));
      end
      for (int i = 0; i < GapLen; i++) begin
        spi_q.push_back(make_item('0, '0, '0, KIND_GAP, (i == GapLen - 1)));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spi_item_t got;
    spi_item_t want;
    if (!rst_ni) begin
      spi_q.delete();
      rgb_order      = 1'b0;
      leds_per_frame = 7'd1;
      guard_len      = 4'd0;
      pixel_pos      = 0;
      fails          = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = make_item(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                        kind_e'(m_axis_tuser), m_axis_tlast);
        if (spi_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected item: codes %h %h %h kind %0d end %b", $time,
                   got.first_code, got.second_code, got.third_code, got.kind, got.frame_end);
        end else begin
          want = spi_q.pop_front();
          if (got.first_code !== want.first_code || got.second_code !== want.second_code ||
              got.third_code !== want.third_code || got.kind !== want.kind ||
              got.frame_end !== want.frame_end) begin
            fails++;
            $display("%0t: mismatch: expected codes %h %h %h kind %0d end %b", $time,
                     want.first_code, want.second_code, want.third_code, want.kind,
                     want.frame_end);
            $display("%0t:           actual codes %h %h %h kind %0d end %b", $time,
                     got.first_code, got.second_code, got.third_code, got.kind, got.frame_end);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_COLOR_ORDER: rgb_order      = cfg_wdata_i[0];
          CFG_LED_COUNT:   leds_per_frame = cfg_wdata_i[6:0];
          CFG_TAIL_GUARD:  guard_len      = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata);
      fail_count_o <= fails;
      pending_o    <= spi_q.size();
    end
  end

endmodule

/* dv/ws2812_spi_frame_encoder_unit_tb.sv */
// testbench top for the ws2812 spi frame encoder: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module ws2812_spi_frame_encoder_unit_tb;
  import wsenc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;  // red, green, blue
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [95:0]         m_axis_tdata;        // first_code, second_code, third_code
  logic [1:0]          m_axis_tuser;        // item_kind
  logic                m_axis_tlast;        // frame_end
  int                  fail_count;
  int                  pending;
  int                  idle_pct      = 24;

  ws2812_spi_frame_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ws2812_spi_frame_encoder_unit_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [23:0] rgb);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rgb;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // stop sending and wait until every predicted item has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int n_items;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset: grb, one led per frame, no guard
    write_reg(CfgIdxSpare, 7'h7F);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h0000FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF0000);
    send_pixel(24'hAA55AA);

    drain_results();
    write_reg(CFG_COLOR_ORDER, 7'h55);
    write_reg(CFG_LED_COUNT, 7'd3);
    write_reg(CFG_TAIL_GUARD, 7'h7F);
    send_pixel(24'h123456);
    send_pixel(24'h89ABCD);
    send_pixel(24'hFEDCBA);
    send_pixel(24'h0F0F0F);

    // count drops below the current position mid-frame
    drain_results();
    write_reg(CFG_LED_COUNT, 7'd1);
    send_pixel(24'h5A5A5A);

    // zero count acts as one
    drain_results();
    write_reg(CFG_LED_COUNT, 7'd0);
    write_reg(CFG_TAIL_GUARD, 7'h70);
    write_reg(CFG_COLOR_ORDER, 7'h7E);
    send_pixel(24'hC3C3C3);
    send_pixel(24'h3C3C3C);

    // count above the maximum saturates
    drain_results();
    write_reg(CFG_LED_COUNT, 7'h7F);
    write_reg(CFG_TAIL_GUARD, 7'd1);
    send_pixel(24'h808080);
    send_pixel(24'h010101);

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      idle_pct = (ph == 4) ? 0 : 24;
      write_reg(CFG_COLOR_ORDER, CfgDataW'($urandom));
      write_reg(CFG_TAIL_GUARD, CfgDataW'($urandom));
      if (ph == 2) begin
        write_reg(CFG_LED_COUNT, CfgDataW'($urandom_range(64, 127)));
        n_items = 66;
      end else begin
        write_reg(CFG_LED_COUNT, CfgDataW'($urandom_range(0, 8)));
        n_items = 10;
      end
      for (int i = 0; i < n_items; i++) begin
        send_pixel(24'($urandom));
      end
    end
    idle_pct = 24;

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
